/* src/cdxf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Curved dual crossfader package
// Shared widths, types, register indexes and curve codes for the crossfader.
// ----------------------------------------------------------------------------
package cdxf_pkg;

  // Sample width, Q4.11 volts at the default of 16 bits (legal range 12 to 32).
  localparam int SAMPLE_BITS = 16;

  // Weighted products and the rounded mix before clipping.
  localparam int PROD_W = SAMPLE_BITS + 17;
  localparam int MIX_W  = PROD_W + 1 - 15;

  // Pipeline depth: the position path fills the first stages, the mix the rest.
  localparam int POS_STAGES = 4;
  localparam int N_STAGES   = 9;

  // Position arithmetic, Q1.14.
  localparam int Q14_ONE = 16384;

  // CV term is round(cv * trim / 10240): add half, drop 11 bits, then divide
  // by five through a reciprocal multiply on a biased, non-negative value.
  localparam logic signed [32:0] CV_HALF     = 33'sd5120;
  localparam logic        [21:0] DIV5_BIAS   = 22'd2621440;
  localparam logic        [29:0] DIV5_MAGIC  = 30'd858993460;
  localparam logic signed [20:0] DIV5_OFFSET = 21'sd524288;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LIMIT = 2'd1;

  // Curve codes; any other code behaves as linear.
  localparam logic [1:0] CURVE_LOG = 2'd0;
  localparam logic [1:0] CURVE_LIN = 2'd1;
  localparam logic [1:0] CURVE_EXP = 2'd2;

  localparam logic [14:0] CLIP_RESET = 15'd20480;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [15:0]            ctrl_t;
  typedef logic [14:0]                   mag_t;

  typedef struct packed {
    logic [1:0]  curve_mode;
    logic [14:0] clip_limit;
  } cfg_t;

endpackage

/* src/curved_dual_crossfader_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Curved dual crossfader, top level
// One section of a curved A/B crossfader with a master position, a fade curve
// and a symmetric output clip, built as a nine stage pipeline.
// ----------------------------------------------------------------------------
//   Channel  Handshake            Carries
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data (curve_mode, clip_limit)
//   in       in_valid/in_stall    two samples, section and master controls
//   out      out_valid/out_stall  faded_out, flipped_out
//
// One item enters per cycle while in_stall is low; the pipeline depth is set
// by the two multiplier stages of the CV divide, the curve square and the
// weighted products, each followed by a register.
// Reset (rst, synchronous) empties the pipeline and sets curve_mode to linear
// and clip_limit to 10 V. Each stage moves when its successor is free, so a
// stall on the output fills bubbles first and pushes back to in_stall only
// when every stage holds an item. The final stage is the output register.
// ----------------------------------------------------------------------------
module curved_dual_crossfader_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cdxf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cdxf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  cdxf_pkg::sample_t                  sample_a,
  input  cdxf_pkg::sample_t                  sample_b,
  input  cdxf_pkg::ctrl_t                    section_knob,
  input  cdxf_pkg::ctrl_t                    section_trim,
  input  cdxf_pkg::ctrl_t                    section_cv,
  input  logic                               section_cv_present,
  input  cdxf_pkg::ctrl_t                    master_knob,
  input  cdxf_pkg::ctrl_t                    master_trim,
  input  cdxf_pkg::ctrl_t                    master_cv,
  input  logic                               master_cv_present,
  output logic                               out_valid,
  input  logic                               out_stall,
  output cdxf_pkg::sample_t                  faded_out,
  output cdxf_pkg::sample_t                  flipped_out
);
  import cdxf_pkg::*;

  // Configuration registers. Writes are always taken; an unknown index is
  // simply ignored. Values are to be changed only while the pipeline is empty; the block does not enforce it.
  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.curve_mode <= CURVE_LIN;
      cfg.clip_limit <= CLIP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CURVE_MODE: cfg.curve_mode <= cfg_data[1:0];
        REG_CLIP_LIMIT: cfg.clip_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valid bits and load enables. A stage may load when it is empty or
  // when the stage after it is loading too, so bubbles collapse under a stall.
  logic [N_STAGES:1] v;
  logic [N_STAGES:1] load;

  always_comb begin
    load[N_STAGES] = !v[N_STAGES] || !out_stall;
    for (int k = N_STAGES - 1; k >= 1; k--) begin
      load[k] = !v[k] || load[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (load[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= N_STAGES; k++) begin
        if (load[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign in_stall  = !load[1];
  assign out_valid = v[N_STAGES];

  // Position path: stages one to four.
  logic    pos_neg;
  mag_t    pos_mag;
  sample_t pos_a, pos_b;

  cdxf_position u_position (
    .clk                (clk),
    .load               (load[POS_STAGES:1]),
    .sample_a           (sample_a),
    .sample_b           (sample_b),
    .section_knob       (section_knob),
    .section_trim       (section_trim),
    .section_cv         (section_cv),
    .section_cv_present (section_cv_present),
    .master_knob        (master_knob),
    .master_trim        (master_trim),
    .master_cv          (master_cv),
    .master_cv_present  (master_cv_present),
    .pos_neg            (pos_neg),
    .pos_mag            (pos_mag),
    .pos_a              (pos_a),
    .pos_b              (pos_b)
  );

  // Curve, weights, mix and clip: stages five to nine.
  cdxf_mix u_mix (
    .clk         (clk),
    .load        (load[N_STAGES:POS_STAGES+1]),
    .cfg         (cfg),
    .pos_neg     (pos_neg),
    .pos_mag     (pos_mag),
    .pos_a       (pos_a),
    .pos_b       (pos_b),
    .faded_out   (faded_out),
    .flipped_out (flipped_out)
  );

`ifndef SYNTHESIS
  // Back pressure reaches the input only when every stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v == '1))
    else $error("input stalled while the pipeline has a free stage");

  // A free output register always lets the input through.
  a_free_out: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled although the output is free");

  // A stage that could not move keeps its item.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (($past(v & ~load) & ~v) == '0))
    else $error("a held pipeline item was lost");

  // An accepted item always lands in the first stage.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> v[1])
    else $error("accepted item did not enter the pipeline");
`endif

endmodule

/* src/cdxf_position.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crossfader position pipeline
// Four stages from knobs, trims and CVs to the sign and magnitude of the
// clamped section position.
// ----------------------------------------------------------------------------
module cdxf_position (
  input  logic                                   clk,
  input  logic [cdxf_pkg::POS_STAGES:1]          load,
  input  cdxf_pkg::sample_t                      sample_a,
  input  cdxf_pkg::sample_t                      sample_b,
  input  cdxf_pkg::ctrl_t                        section_knob,
  input  cdxf_pkg::ctrl_t                        section_trim,
  input  cdxf_pkg::ctrl_t                        section_cv,
  input  logic                                   section_cv_present,
  input  cdxf_pkg::ctrl_t                        master_knob,
  input  cdxf_pkg::ctrl_t                        master_trim,
  input  cdxf_pkg::ctrl_t                        master_cv,
  input  logic                                   master_cv_present,
  output logic                                   pos_neg,
  output cdxf_pkg::mag_t                         pos_mag,
  output cdxf_pkg::sample_t                      pos_a,
  output cdxf_pkg::sample_t                      pos_b
);
  import cdxf_pkg::*;

  function automatic logic [21:0] div5_prep(input logic signed [31:0] p);
    logic signed [32:0] t;
    logic [21:0] q;
    t = {p[31], p} + CV_HALF;
    q = t[32:11];
    return q + DIV5_BIAS;
  endfunction

  function automatic ctrl_t clamp_one(input logic signed [21:0] v);
    if (v > 22'sd16384) begin
      return 16'sd16384;
    end else if (v < -22'sd16384) begin
      return -16'sd16384;
    end
    return v[15:0];
  endfunction

  // Stage 1: CV times trim.
  logic signed [31:0] prod_m1, prod_s1;
  ctrl_t              m_knob1, s_knob1;
  logic               m_on1, s_on1;
  sample_t            a1, b1;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      prod_m1 <= master_cv * master_trim;
      prod_s1 <= section_cv * section_trim;
      m_knob1 <= master_knob;
      s_knob1 <= section_knob;
      m_on1   <= master_cv_present;
      s_on1   <= section_cv_present;
      a1      <= sample_a;
      b1      <= sample_b;
    end
  end

  // Stage 2: rounded shift, then the reciprocal multiply for the divide by five.
  logic [51:0] full_m, full_s;
  logic [19:0] quo_m2, quo_s2;
  ctrl_t       m_knob2, s_knob2;
  logic        m_on2, s_on2;
  sample_t     a2, b2;

  always_comb begin
    full_m = {30'b0, div5_prep(prod_m1)} * {22'b0, DIV5_MAGIC};
    full_s = {30'b0, div5_prep(prod_s1)} * {22'b0, DIV5_MAGIC};
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      quo_m2  <= full_m[51:32];
      quo_s2  <= full_s[51:32];
      m_knob2 <= m_knob1;
      s_knob2 <= s_knob1;
      m_on2   <= m_on1;
      s_on2   <= s_on1;
      a2      <= a1;
      b2      <= b1;
    end
  end

  // Stage 3: master position, clamped.
  logic signed [20:0] term_m, term_s;
  logic signed [21:0] master_sum;
  ctrl_t              master3, s_knob3;
  logic signed [20:0] s_term3;
  sample_t            a3, b3;

  always_comb begin
    term_m     = signed'({1'b0, quo_m2}) - DIV5_OFFSET;
    term_s     = signed'({1'b0, quo_s2}) - DIV5_OFFSET;
    master_sum = 22'(m_knob2) + (m_on2 ? 22'(term_m) : 22'sd0);
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      master3 <= clamp_one(master_sum);
      s_knob3 <= s_knob2;
      s_term3 <= s_on2 ? term_s : 21'sd0;
      a3      <= a2;
      b3      <= b2;
    end
  end

  // Stage 4: section position, clamped, split into sign and magnitude.
  logic signed [21:0] pos_sum;
  ctrl_t              pos;

  always_comb begin
    pos_sum = 22'(s_knob3) + 22'(master3) + 22'(s_term3);
    pos     = clamp_one(pos_sum);
  end

  always_ff @(posedge clk) begin
    if (load[4]) begin
      pos_neg <= pos[15];
      pos_mag <= pos[15] ? 15'(-pos) : pos[14:0];
      pos_a   <= a3;
      pos_b   <= b3;
    end
  end

endmodule

/* src/cdxf_mix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crossfader curve and mix pipeline
// Five stages: curve square, weights, weighted products, rounded sums, clip.
// ----------------------------------------------------------------------------
module cdxf_mix (
  input  logic                                          clk,
  input  logic [cdxf_pkg::N_STAGES:cdxf_pkg::POS_STAGES+1] load,
  input  cdxf_pkg::cfg_t                                cfg,
  input  logic                                          pos_neg,
  input  cdxf_pkg::mag_t                                pos_mag,
  input  cdxf_pkg::sample_t                             pos_a,
  input  cdxf_pkg::sample_t                             pos_b,
  output cdxf_pkg::sample_t                             faded_out,
  output cdxf_pkg::sample_t                             flipped_out
);
  import cdxf_pkg::*;

  localparam logic signed [MIX_W-1:0] SMAX =
    MIX_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [MIX_W-1:0] SMIN = -SMAX - MIX_W'(1);

  // Stage 5: square of the magnitude, or of its distance from one.
  mag_t        f;
  logic [29:0] sq5;
  mag_t        mag5;
  logic        neg5;
  sample_t     a5, b5;

  always_comb begin
    f = (cfg.curve_mode == CURVE_EXP) ? 15'(Q14_ONE) - pos_mag : pos_mag;
  end

  always_ff @(posedge clk) begin
    if (load[5]) begin
      sq5  <= {15'b0, f} * {15'b0, f};
      mag5 <= pos_mag;
      neg5 <= pos_neg;
      a5   <= pos_a;
      b5   <= pos_b;
    end
  end

  // Stage 6: shaped position and the two weights, in units of 1/32768.
  logic [29:0] sq_round;
  mag_t        r, shaped;
  logic [15:0] wb, wa6, wb6;
  sample_t     a6, b6;

  always_comb begin
    sq_round = sq5 + 30'd8192;
    r        = sq_round[28:14];
    case (cfg.curve_mode)
      CURVE_LOG: shaped = r;
      CURVE_EXP: shaped = 15'(Q14_ONE) - r;
      CURVE_LIN: shaped = mag5;
      default:   shaped = mag5;
    endcase
    wb = neg5 ? 16'(Q14_ONE) - {1'b0, shaped} : 16'(Q14_ONE) + {1'b0, shaped};
  end

  always_ff @(posedge clk) begin
    if (load[6]) begin
      wb6 <= wb;
      wa6 <= 16'd32768 - wb;
      a6  <= a5;
      b6  <= b5;
    end
  end

  // Stage 7: the four weighted products.
  logic signed [PROD_W-1:0] fa7, fb7, ga7, gb7;

  always_ff @(posedge clk) begin
    if (load[7]) begin
      fa7 <= signed'({1'b0, wa6}) * a6;
      fb7 <= signed'({1'b0, wb6}) * b6;
      ga7 <= signed'({1'b0, wb6}) * a6;
      gb7 <= signed'({1'b0, wa6}) * b6;
    end
  end

  // Stage 8: sums rounded to nearest, ties up.
  logic signed [PROD_W:0]  sum_f, sum_g;
  logic signed [MIX_W-1:0] mix_f8, mix_g8;

  always_comb begin
    sum_f = (PROD_W+1)'(fa7) + (PROD_W+1)'(fb7) + (PROD_W+1)'(Q14_ONE);
    sum_g = (PROD_W+1)'(ga7) + (PROD_W+1)'(gb7) + (PROD_W+1)'(Q14_ONE);
  end

  always_ff @(posedge clk) begin
    if (load[8]) begin
      mix_f8 <= sum_f[PROD_W:15];
      mix_g8 <= sum_g[PROD_W:15];
    end
  end

  // Stage 9: symmetric clip, folded together with the sample range.
  logic signed [MIX_W-1:0] lim, hi, lo;
  logic signed [MIX_W-1:0] clip_f, clip_g;

  always_comb begin
    lim = signed'({{(MIX_W-15){1'b0}}, cfg.clip_limit});
    hi  = (lim > SMAX) ? SMAX : lim;
    lo  = (lim > SMAX) ? SMIN : -lim;
    clip_f = (mix_f8 > hi) ? hi : ((mix_f8 < lo) ? lo : mix_f8);
    clip_g = (mix_g8 > hi) ? hi : ((mix_g8 < lo) ? lo : mix_g8);
  end

  always_ff @(posedge clk) begin
    if (load[9]) begin
      faded_out   <= clip_f[SAMPLE_BITS-1:0];
      flipped_out <= clip_g[SAMPLE_BITS-1:0];
    end
  end

endmodule

/* bench/crossfade_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crossfader result checker
// Watches the register, input and output channels of the crossfader. It keeps
// its own copy of the registers, works out both mixes for every accepted item
// and compares each accepted result, in order, with the oldest one due.
// ----------------------------------------------------------------------------
module crossfade_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [cdxf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cdxf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  cdxf_pkg::sample_t                  sample_a,
  input  cdxf_pkg::sample_t                  sample_b,
  input  cdxf_pkg::ctrl_t                    section_knob,
  input  cdxf_pkg::ctrl_t                    section_trim,
  input  cdxf_pkg::ctrl_t                    section_cv,
  input  logic                               section_cv_present,
  input  cdxf_pkg::ctrl_t                    master_knob,
  input  cdxf_pkg::ctrl_t                    master_trim,
  input  cdxf_pkg::ctrl_t                    master_cv,
  input  logic                               master_cv_present,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  cdxf_pkg::sample_t                  faded_out,
  input  cdxf_pkg::sample_t                  flipped_out,
  output int                                 fail_count,
  output int                                 awaiting
);
  import cdxf_pkg::*;

  typedef struct packed {
    sample_t faded;
    sample_t flipped;
  } mix_pair_t;

  localparam longint Q14     = 16384;
  localparam longint CV_STEP = 10240;

  mix_pair_t   crossfade_due[$];
  mix_pair_t   due;
  logic [1:0]  curve_now;
  logic [14:0] clip_now;
  int          errors = 0;

  // Division rounded to nearest, ties toward +infinity.
  function automatic longint round_div(longint n, longint d);
    longint t;
    longint q;
    t = n + d / 2;
    q = t / d;
    if ((t % d) != 0 && t < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic longint bound(longint v, longint lo, longint hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // CV scaled by trim and divided by 5 V, in Q1.14.
  function automatic longint cv_term(ctrl_t cv, ctrl_t trim);
    return round_div(longint'(cv) * longint'(trim), CV_STEP);
  endfunction

  function automatic sample_t clip_mix(longint v, logic [14:0] clip);
    longint top_code;
    longint lim;
    top_code = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lim      = longint'(clip);
    return sample_t'(bound(bound(v, -lim, lim), -top_code - 1, top_code));
  endfunction

  function automatic mix_pair_t predict_crossfade(
    sample_t a, sample_t b,
    ctrl_t s_knob, ctrl_t s_trim, ctrl_t s_cv, logic s_on,
    ctrl_t m_knob, ctrl_t m_trim, ctrl_t m_cv, logic m_on,
    logic [1:0] curve, logic [14:0] clip);
    longint    master;
    longint    pos;
    longint    mag;
    longint    shaped;
    longint    fall;
    longint    wb;
    longint    wa;
    mix_pair_t r;
    master = longint'(m_knob);
    if (m_on) begin
      master = master + cv_term(m_cv, m_trim);
    end
    master = bound(master, -Q14, Q14);
    pos = longint'(s_knob) + master;
    if (s_on) begin
      pos = pos + cv_term(s_cv, s_trim);
    end
    pos = bound(pos, -Q14, Q14);
    mag = (pos < 0) ? -pos : pos;
    case (curve)
      CURVE_LOG: begin
        shaped = (mag * mag + Q14 / 2) >>> 14;
      end
      CURVE_EXP: begin
        fall   = Q14 - mag;
        shaped = Q14 - ((fall * fall + Q14 / 2) >>> 14);
      end
      default: begin
        shaped = mag;
      end
    endcase
    if (pos < 0) begin
      shaped = -shaped;
    end
    // Weight of B in units of 1/32768; A takes the rest.
    wb = shaped + Q14;
    wa = 2 * Q14 - wb;
    r.faded   = clip_mix(round_div(wa * longint'(a) + wb * longint'(b), 2 * Q14), clip);
    r.flipped = clip_mix(round_div(wb * longint'(a) + wa * longint'(b), 2 * Q14), clip);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      curve_now <= CURVE_LIN;
      clip_now  <= CLIP_RESET;
      crossfade_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CURVE_MODE) begin
          curve_now <= cfg_data[1:0];
        end else if (cfg_index == REG_CLIP_LIMIT) begin
          clip_now <= cfg_data;
        end
      end
      if (out_valid && !out_stall) begin
        if (crossfade_due.size() == 0) begin
          $error("result with no item waiting: faded_out %0d, flipped_out %0d",
                 faded_out, flipped_out);
          errors++;
        end else begin
          due = crossfade_due.pop_front();
          if (faded_out !== due.faded) begin
            $error("faded_out: expected %0d, actual %0d", due.faded, faded_out);
            errors++;
          end
          if (flipped_out !== due.flipped) begin
            $error("flipped_out: expected %0d, actual %0d", due.flipped, flipped_out);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        crossfade_due.push_back(predict_crossfade(
          sample_a, sample_b,
          section_knob, section_trim, section_cv, section_cv_present,
          master_knob, master_trim, master_cv, master_cv_present,
          curve_now, clip_now));
      end
    end
    fail_count <= errors;
    awaiting   <= crossfade_due.size();
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Curved dual crossfader testbench
// Drives directed corner items under every curve and then phases of random
// items under changing curve and clip settings, with random idling on both
// channels. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import cdxf_pkg::*;

  // The watchdog ends the run after this many cycles with no handshake on any
  // channel. A correct run never comes close: the longest quiet stretch is the
  // reset, one input gap, one output stall burst and the nine stage pipeline.
  localparam int QUIET_LIMIT  = 1000;
  // Extra cycles after the last result, so that a stray result still shows up.
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 140;

  // The unused curve code, which must behave as linear.
  localparam logic [1:0] CURVE_SPARE = 2'd3;
  // Register indexes with no register behind them; writes there are ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam sample_t SAMPLE_MAX = sample_t'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam sample_t SAMPLE_MIN = ~SAMPLE_MAX;

  typedef struct packed {
    sample_t a;
    sample_t b;
    ctrl_t   s_knob;
    ctrl_t   s_trim;
    ctrl_t   s_cv;
    logic    s_on;
    ctrl_t   m_knob;
    ctrl_t   m_trim;
    ctrl_t   m_cv;
    logic    m_on;
  } fade_item_t;

  logic                  clk                = 1'b0;
  logic                  rst                = 1'b1;
  logic                  cfg_valid          = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index          = '0;
  logic [CFG_DATA_W-1:0] cfg_data           = '0;
  logic                  in_valid           = 1'b0;
  logic                  in_stall;
  sample_t               sample_a           = '0;
  sample_t               sample_b           = '0;
  ctrl_t                 section_knob       = '0;
  ctrl_t                 section_trim       = '0;
  ctrl_t                 section_cv         = '0;
  logic                  section_cv_present = 1'b0;
  ctrl_t                 master_knob        = '0;
  ctrl_t                 master_trim        = '0;
  ctrl_t                 master_cv          = '0;
  logic                  master_cv_present  = 1'b0;
  logic                  out_valid;
  logic                  out_stall          = 1'b0;
  sample_t               faded_out;
  sample_t               flipped_out;

  int fail_count;
  int awaiting;

  // Percent chance, per item or per cycle, that an idle burst starts on the
  // input side and on the output side. Zero gives a stretch with no idling.
  int send_pct  = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int quiet = 0;

  always #4 clk = ~clk;

  curved_dual_crossfader_top dut (.*);

  crossfade_checker u_checker (.*);

  // The output side stalls in bursts of random length.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: a block that stops moving ends the run as a failure.
  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) ||
        (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // A knob or trim value anywhere within plus and minus one.
  function automatic ctrl_t unit_span();
    return ctrl_t'(int'($urandom_range(0, 2 * Q14_ONE)) - Q14_ONE);
  endfunction

  // Samples lean toward the rails and toward small values, where clipping and
  // rounding are most likely to go wrong.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: begin
        return SAMPLE_MAX;
      end
      1: begin
        return SAMPLE_MIN;
      end
      2: begin
        return sample_t'(int'($urandom_range(0, 512)) - 256);
      end
      default: begin
        return sample_t'($urandom);
      end
    endcase
  endfunction

  // Corner items for the directed part. Item zero is all zero.
  function automatic fade_item_t corner_item(int k);
    fade_item_t it;
    it = '0;
    case (k)
      1: begin
        // Section knob hard over to B, inputs on opposite rails.
        it.a      = SAMPLE_MAX;
        it.b      = SAMPLE_MIN;
        it.s_knob = ctrl_t'(Q14_ONE);
      end
      2: begin
        // Master knob hard over to A.
        it.a      = SAMPLE_MIN;
        it.b      = SAMPLE_MAX;
        it.m_knob = ctrl_t'(-Q14_ONE);
      end
      3: begin
        // Knobs, trims and CVs far beyond their nominal range, both CVs
        // connected, so both the master and the section clamp are hit.
        it.a      = SAMPLE_MAX;
        it.b      = SAMPLE_MAX;
        it.s_knob = 16'sh7FFF;
        it.s_trim = 16'sh8000;
        it.s_cv   = 16'sh8000;
        it.s_on   = 1'b1;
        it.m_knob = 16'sh8000;
        it.m_trim = 16'sh7FFF;
        it.m_cv   = 16'sh7FFF;
        it.m_on   = 1'b1;
      end
      4: begin
        // Both CV terms land exactly on a half step, one positive and one
        // negative, so the tie rounding shows.
        it.a      = 16'sd1000;
        it.b      = -16'sd999;
        it.s_knob = 16'sd8192;
        it.s_cv   = 16'sd5;
        it.s_trim = 16'sd1024;
        it.s_on   = 1'b1;
        it.m_cv   = -16'sd5;
        it.m_trim = 16'sd1024;
        it.m_on   = 1'b1;
      end
      5: begin
        // Large CVs that are not connected must have no effect.
        it.a      = SAMPLE_MIN;
        it.b      = 16'sd12345;
        it.s_knob = 16'sd4096;
        it.s_cv   = 16'sh7FFF;
        it.s_trim = ctrl_t'(Q14_ONE);
        it.m_knob = -16'sd8192;
        it.m_cv   = 16'sh7FFF;
        it.m_trim = ctrl_t'(Q14_ONE);
      end
      default: begin
      end
    endcase
    return it;
  endfunction

  // Most random items are well formed: knobs and trims within their range,
  // CVs anywhere. One in eight is pure noise on every field.
  function automatic fade_item_t random_item();
    fade_item_t it;
    if ($urandom_range(0, 7) == 0) begin
      it.a      = sample_t'($urandom);
      it.b      = sample_t'($urandom);
      it.s_knob = ctrl_t'($urandom);
      it.s_trim = ctrl_t'($urandom);
      it.s_cv   = ctrl_t'($urandom);
      it.s_on   = 1'($urandom_range(0, 1));
      it.m_knob = ctrl_t'($urandom);
      it.m_trim = ctrl_t'($urandom);
      it.m_cv   = ctrl_t'($urandom);
      it.m_on   = 1'($urandom_range(0, 1));
    end else begin
      it.a      = pick_sample();
      it.b      = pick_sample();
      it.s_knob = unit_span();
      it.s_trim = unit_span();
      it.s_cv   = ctrl_t'($urandom);
      it.s_on   = 1'($urandom_range(0, 1));
      it.m_knob = unit_span();
      it.m_trim = unit_span();
      it.m_cv   = ctrl_t'($urandom);
      it.m_on   = 1'($urandom_range(0, 1));
    end
    return it;
  endfunction

  // Offers one item, possibly after an idle gap, and returns at the clock
  // edge where the block takes it.
  task automatic send_fade(fade_item_t it);
    if ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    sample_a           <= it.a;
    sample_b           <= it.b;
    section_knob       <= it.s_knob;
    section_trim       <= it.s_trim;
    section_cv         <= it.s_cv;
    section_cv_present <= it.s_on;
    master_knob        <= it.m_knob;
    master_trim        <= it.m_trim;
    master_cv          <= it.m_cv;
    master_cv_present  <= it.m_on;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops offering items and waits until every result has come back, so
  // that the registers can be rewritten safely.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  // One register write; cfg_valid stays high so back to back writes follow
  // without a gap. The caller lowers it once the batch is done.
  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Sets both registers. The curve code rides in the low bits with random
  // junk above it, which the block must mask away. With spare set, the two
  // unused indexes get random writes first, which must change nothing.
  task automatic configure(logic [1:0] curve, logic [14:0] clip, bit spare);
    logic [CFG_DATA_W-1:0] word;
    if (spare) begin
      put_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
      put_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    end
    word      = CFG_DATA_W'($urandom);
    word[1:0] = curve;
    put_reg(REG_CURVE_MODE, word);
    put_reg(REG_CLIP_LIMIT, clip);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase;
    int n;
    int k;
    logic [1:0]  curve;
    logic [14:0] clip;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The first group runs on the reset settings, linear with
    // a 10 V clip; the others cover the log curve with a 10 V clip, the exp curve
    // with the widest clip, and the unused curve code with a clip of zero.
    send_pct  = 20;
    stall_pct <= 20;
    for (k = 0; k < 6; k++) send_fade(corner_item(k));
    settle();
    configure(CURVE_LOG, CLIP_RESET, 1'b1);
    for (k = 0; k < 6; k++) send_fade(corner_item(k));
    settle();
    configure(CURVE_EXP, 15'h7FFF, 1'b0);
    for (k = 0; k < 6; k++) send_fade(corner_item(k));
    settle();
    configure(CURVE_SPARE, '0, 1'b0);
    for (k = 0; k < 6; k++) send_fade(corner_item(k));

    // Random part. Each phase picks a curve and a clip, stepping through the
    // extremes and some random limits, and an idling level; the last two
    // phases run without idling on either side.
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase % 6)
        0: begin
          clip = 15'h7FFF;
        end
        1: begin
          clip = '0;
        end
        2: begin
          clip = CLIP_RESET;
        end
        3: begin
          clip = 15'd1;
        end
        4: begin
          clip = 15'($urandom);
        end
        default: begin
          clip = 15'($urandom_range(0, 4096));
        end
      endcase
      case (phase % 4)
        0: begin
          curve = CURVE_LOG;
        end
        1: begin
          curve = CURVE_LIN;
        end
        2: begin
          curve = CURVE_EXP;
        end
        default: begin
          curve = CURVE_SPARE;
        end
      endcase
      configure(curve, clip, phase % 2 == 1);
      if (phase >= PHASES - 2) begin
        send_pct  = 0;
        stall_pct <= 0;
      end else begin
        case (phase % 3)
          0: begin
            send_pct  = 0;
            stall_pct <= 0;
          end
          1: begin
            send_pct  = 10;
            stall_pct <= 10;
          end
          default: begin
            send_pct  = 35;
            stall_pct <= 35;
          end
        endcase
      end
      for (n = 0; n < PHASE_ITEMS; n++) send_fade(random_item());
    end

    // Drain: every result back, then a short wait for anything unexpected.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaiting == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
